/* hw/rtl/msq_pkg.sv */
// shared types, constants and the tile pattern rom for the marching squares tile renderer
// no dependencies; imported by every module of the block
package msq_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned COORD_W = 10;
  localparam int unsigned CODE_W  = 4;
  localparam int unsigned PAT_W   = 9;
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 5;
  localparam int unsigned MIN_SIZE = 3;

  // register index, taken from paddr[4:2]
  typedef enum logic [2:0] {
    REG_THRESHOLD    = 3'd0,
    REG_FG_COLOUR    = 3'd1,
    REG_BG_COLOUR    = 3'd2,
    REG_IMAGE_WIDTH  = 3'd3,
    REG_IMAGE_HEIGHT = 3'd4
  } reg_idx_e;

  localparam logic [PIX_W-1:0]  RST_THRESHOLD    = 8'd127;
  localparam logic [PIX_W-1:0]  RST_FG_COLOUR    = 8'd255;
  localparam logic [PIX_W-1:0]  RST_BG_COLOUR    = 8'd0;
  localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 11'd480;

  typedef struct packed {
    logic [PIX_W-1:0]  threshold;
    logic [PIX_W-1:0]  fg_colour;
    logic [PIX_W-1:0]  bg_colour;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
  } cfg_t;

  // one finished tile handed from the scan stage to the emitter
  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CODE_W-1:0]  code;
  } tile_t;

  // tile element k in raster order sits at bit (8 - k)
  function automatic logic [PAT_W-1:0] tile_pattern(input logic [CODE_W-1:0] code);
    logic [PAT_W-1:0] pat;
    unique case (code)
      4'd0:  pat = 9'h1FF;
      4'd1:  pat = 9'h1D9;
      4'd2:  pat = 9'h1F4;
      4'd3:  pat = 9'h1C0;
      4'd4:  pat = 9'h137;
      4'd5:  pat = 9'h1AB;
      4'd6:  pat = 9'h124;
      4'd7:  pat = 9'h1A0;
      4'd8:  pat = 9'h05F;
      4'd9:  pat = 9'h049;
      4'd10: pat = 9'h0EE;
      4'd11: pat = 9'h0C8;
      4'd12: pat = 9'h007;
      4'd13: pat = 9'h00B;
      4'd14: pat = 9'h026;
      default: pat = 9'h000;
    endcase
    return pat;
  endfunction

endpackage

/* hw/rtl/marching_squares_tile_renderer_core.sv */
// path: with the emitter idle, a tile's bottom-right pixel goes to the scan tile register, then
// into the emitter output register as its first result item; the other eight follow one per cycle
// while out_ready_i is high; throughput: one pixel per cycle; only a tile-completing pixel stalls,
// while a finished tile still waits for the emitter; on the bottom row of each tile row the
// nine-item emitter sets the pace of a steady stream
// reset: asynchronous active low; registers to defaults, counters to zero, line store kept as is
module marching_squares_tile_renderer_core #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [msq_pkg::APB_AW-1:0]    paddr,
  input  logic [msq_pkg::APB_DW-1:0]    pwdata,
  output logic [msq_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  // pixel input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [msq_pkg::PIX_W-1:0]     pixel_i,
  // rendered pixel output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msq_pkg::COORD_W-1:0]   x_o,
  output logic [msq_pkg::COORD_W-1:0]   y_o,
  output logic [msq_pkg::PIX_W-1:0]     colour_o,
  output logic                          last_o
);
  import msq_pkg::*;

  // live configuration, to be changed by the user only while the block is idle; not enforced here
  cfg_t  cfg;

  // one finished tile between the scan stage and the emitter
  tile_t tile;
  logic  tile_valid;
  logic  tile_ready;

  msq_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // scan stage: tracks column/row, classifies corners as dark, keeps top corners of
  // each tile column in the line store and captures a tile code at its bottom-right pixel
  msq_scan #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pixel_i      (pixel_i),
    .tile_valid_o (tile_valid),
    .tile_ready_i (tile_ready),
    .tile_o       (tile)
  );

  // emitter: rom lookup of the pattern, then nine items in raster order within the tile;
  // it takes the next tile in the same cycle its ninth item leaves
  msq_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .tile_valid_i (tile_valid),
    .tile_ready_o (tile_ready),
    .tile_i       (tile),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .x_o          (x_o),
    .y_o          (y_o),
    .colour_o     (colour_o),
    .last_o       (last_o)
  );

endmodule

/* hw/rtl/msq_cfg_regs.sv */
// apb configuration registers of the marching squares tile renderer
// depends on msq_pkg
module msq_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [msq_pkg::APB_AW-1:0]     paddr,
  input  logic [msq_pkg::APB_DW-1:0]     pwdata,
  output logic [msq_pkg::APB_DW-1:0]     prdata,
  output logic                           pready,
  output msq_pkg::cfg_t                  cfg_o
);
  import msq_pkg::*;

  cfg_t       cfg_q;
  logic       wr_en;
  logic [2:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[4:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold    <= RST_THRESHOLD;
      cfg_q.fg_colour    <= RST_FG_COLOUR;
      cfg_q.bg_colour    <= RST_BG_COLOUR;
      cfg_q.image_width  <= RST_IMAGE_WIDTH;
      cfg_q.image_height <= RST_IMAGE_HEIGHT;
    end else if (wr_en) begin
      unique case (idx)
        REG_THRESHOLD:    cfg_q.threshold    <= pwdata[PIX_W-1:0];
        REG_FG_COLOUR:    cfg_q.fg_colour    <= pwdata[PIX_W-1:0];
        REG_BG_COLOUR:    cfg_q.bg_colour    <= pwdata[PIX_W-1:0];
        REG_IMAGE_WIDTH:  cfg_q.image_width  <= pwdata[SIZE_W-1:0];
        REG_IMAGE_HEIGHT: cfg_q.image_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_THRESHOLD:    prdata = APB_DW'(cfg_q.threshold);
      REG_FG_COLOUR:    prdata = APB_DW'(cfg_q.fg_colour);
      REG_BG_COLOUR:    prdata = APB_DW'(cfg_q.bg_colour);
      REG_IMAGE_WIDTH:  prdata = APB_DW'(cfg_q.image_width);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(cfg_q.image_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* hw/rtl/msq_scan.sv */
// raster scan stage: position counters, corner classification, line store of top corners
// depends on msq_pkg; feeds one finished tile at a time to msq_emit
module msq_scan #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  msq_pkg::cfg_t               cfg_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [msq_pkg::PIX_W-1:0]   pixel_i,
  output logic                        tile_valid_o,
  input  logic                        tile_ready_i,
  output msq_pkg::tile_t              tile_o
);
  import msq_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_WIDTH + 3);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT + 3);
  localparam int unsigned WCW   = (CW > SIZE_W) ? CW : SIZE_W;
  localparam int unsigned HCW   = (RW > SIZE_W) ? RW : SIZE_W;
  localparam int unsigned DEPTH = MAX_WIDTH / 3;
  localparam int unsigned TCW   = $clog2(DEPTH + 1);
  localparam int unsigned IDXW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // position state; cend/rend are the last column/row of the current tile
  logic [CW-1:0]   col_q, col_d, cend_q, cend_d;
  logic [RW-1:0]   row_q, row_d, rend_q, rend_d;
  logic [1:0]      cpos_q, cpos_d, rpos_q, rpos_d;
  logic [TCW-1:0]  tc_q, tc_d;
  logic            bl_q;

  logic            s1_valid_q;
  logic [COORD_W-1:0] s1_x_q, s1_y_q;
  logic            s1_dark_q, s1_bl_q;

  // line store, one bit per top corner of each tile column
  logic            tl_mem [DEPTH];
  logic            tr_mem [DEPTH];
  logic            rd_tl_q, rd_tr_q;

  logic [WCW-1:0]  w_raw;
  logic [HCW-1:0]  h_raw;
  logic [CW-1:0]   w_eff;
  logic [RW-1:0]   h_eff;
  logic            dark, in_range, tile_done, accept;
  logic            wr_tl, wr_tr, rd_en;
  logic [IDXW-1:0] mem_idx;

  always_comb begin
    w_raw = WCW'(cfg_i.image_width);
    h_raw = HCW'(cfg_i.image_height);
    if (w_raw < WCW'(MIN_SIZE)) begin
      w_eff = CW'(MIN_SIZE);
    end else if (w_raw > WCW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(w_raw);
    end
    if (h_raw < HCW'(MIN_SIZE)) begin
      h_eff = RW'(MIN_SIZE);
    end else if (h_raw > HCW'(MAX_HEIGHT)) begin
      h_eff = RW'(MAX_HEIGHT);
    end else begin
      h_eff = RW'(h_raw);
    end
  end

  assign dark      = (pixel_i <= cfg_i.threshold);
  assign in_range  = (cend_q < w_eff) && (rend_q < h_eff);
  assign tile_done = in_range && (rpos_q == 2'd2) && (cpos_q == 2'd2);
  assign in_ready_o = !tile_done || !s1_valid_q || tile_ready_i;
  assign accept    = in_valid_i && in_ready_o;

  assign wr_tl   = accept && in_range && (rpos_q == 2'd0) && (cpos_q == 2'd0);
  assign wr_tr   = accept && in_range && (rpos_q == 2'd0) && (cpos_q == 2'd2);
  assign rd_en   = accept && tile_done;
  assign mem_idx = tc_q[IDXW-1:0];

  always_comb begin
    col_d  = col_q;
    cpos_d = cpos_q;
    tc_d   = tc_q;
    cend_d = cend_q;
    row_d  = row_q;
    rpos_d = rpos_q;
    rend_d = rend_q;
    if (col_q + CW'(1) >= w_eff) begin
      col_d  = '0;
      cpos_d = 2'd0;
      tc_d   = '0;
      cend_d = CW'(2);
      if (row_q + RW'(1) >= h_eff) begin
        row_d  = '0;
        rpos_d = 2'd0;
        rend_d = RW'(2);
      end else begin
        row_d = row_q + RW'(1);
        if (rpos_q == 2'd2) begin
          rpos_d = 2'd0;
          rend_d = rend_q + RW'(3);
        end else begin
          rpos_d = rpos_q + 2'd1;
        end
      end
    end else begin
      col_d = col_q + CW'(1);
      if (cpos_q == 2'd2) begin
        cpos_d = 2'd0;
        tc_d   = tc_q + TCW'(1);
        cend_d = cend_q + CW'(3);
      end else begin
        cpos_d = cpos_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      cpos_q     <= 2'd0;
      tc_q       <= '0;
      cend_q     <= CW'(2);
      row_q      <= '0;
      rpos_q     <= 2'd0;
      rend_q     <= RW'(2);
      bl_q       <= 1'b0;
      s1_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        col_q  <= col_d;
        cpos_q <= cpos_d;
        tc_q   <= tc_d;
        cend_q <= cend_d;
        row_q  <= row_d;
        rpos_q <= rpos_d;
        rend_q <= rend_d;
        if (in_range && (rpos_q == 2'd2) && (cpos_q == 2'd0)) begin
          bl_q <= dark;
        end
      end
      if (rd_en) begin
        s1_valid_q <= 1'b1;
      end else if (tile_ready_i) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // tile payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_x_q    <= COORD_W'(cend_q - CW'(2));
      s1_y_q    <= COORD_W'(row_q - RW'(2));
      s1_dark_q <= dark;
      s1_bl_q   <= bl_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_tl) begin
      tl_mem[mem_idx] <= dark;
    end
    if (wr_tr) begin
      tr_mem[mem_idx] <= dark;
    end
    if (rd_en) begin
      rd_tl_q <= tl_mem[mem_idx];
      rd_tr_q <= tr_mem[mem_idx];
    end
  end

  assign tile_valid_o = s1_valid_q;
  assign tile_o.x     = s1_x_q;
  assign tile_o.y     = s1_y_q;
  assign tile_o.code  = {rd_tl_q, rd_tr_q, s1_dark_q, s1_bl_q};

  // tile end column tracks the column counter
  a_cend_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cend_q == col_q - CW'(cpos_q) + CW'(2))
    else $error("tile end column out of step with column counter");

  // a finished tile always lands in the tile register
  a_tile_capture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |=> s1_valid_q)
    else $error("finished tile not captured");

  // a pending tile is not dropped while the emitter is busy
  a_tile_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !tile_ready_i) |=> (s1_valid_q && $stable(s1_x_q) && $stable(s1_y_q)))
    else $error("pending tile lost or changed");

  // input only stalls on a tile-completing pixel behind a pending tile
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (tile_done && s1_valid_q))
    else $error("input stalled without a pending tile");

endmodule

/* hw/rtl/msq_emit.sv */
// tile emitter: expands one tile code into nine coloured pixels, one per cycle
// while out_ready_i is high; depends on msq_pkg; output register of the block
module msq_emit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  msq_pkg::cfg_t                 cfg_i,
  input  logic                          tile_valid_i,
  output logic                          tile_ready_o,
  input  msq_pkg::tile_t                tile_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [msq_pkg::COORD_W-1:0]   x_o,
  output logic [msq_pkg::COORD_W-1:0]   y_o,
  output logic [msq_pkg::PIX_W-1:0]     colour_o,
  output logic                          last_o
);
  import msq_pkg::*;

  logic               ev_q;
  logic [COORD_W-1:0] x_q, y_q;
  logic [1:0]         kcol_q, krow_q;
  logic [PAT_W-1:0]   pat_q;
  logic               last, step, load;

  assign last         = (kcol_q == 2'd2) && (krow_q == 2'd2);
  assign step         = ev_q && out_ready_i;
  assign tile_ready_o = !ev_q || (out_ready_i && last);
  assign load         = tile_valid_i && tile_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q   <= 1'b0;
      kcol_q <= 2'd0;
      krow_q <= 2'd0;
    end else if (load) begin
      ev_q   <= 1'b1;
      kcol_q <= 2'd0;
      krow_q <= 2'd0;
    end else if (step) begin
      if (last) begin
        ev_q <= 1'b0;
      end
      if (kcol_q == 2'd2) begin
        kcol_q <= 2'd0;
        krow_q <= (krow_q == 2'd2) ? 2'd0 : krow_q + 2'd1;
      end else begin
        kcol_q <= kcol_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      x_q   <= tile_i.x;
      y_q   <= tile_i.y;
      pat_q <= tile_pattern(tile_i.code);
    end else if (step) begin
      pat_q <= {pat_q[PAT_W-2:0], 1'b0};
      if (kcol_q == 2'd2) begin
        x_q <= x_q - COORD_W'(2);
        y_q <= y_q + COORD_W'(1);
      end else begin
        x_q <= x_q + COORD_W'(1);
      end
    end
  end

  assign out_valid_o = ev_q;
  assign x_o         = x_q;
  assign y_o         = y_q;
  assign colour_o    = pat_q[PAT_W-1] ? cfg_i.fg_colour : cfg_i.bg_colour;
  assign last_o      = last;

  a_sub_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (kcol_q != 2'd3) && (krow_q != 2'd3))
    else $error("tile element counter out of range");

  // a tile ends after its ninth pixel unless the next one is loaded
  a_tile_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && last && !load) |=> !ev_q)
    else $error("emitter kept running after the last pixel");

  // inside a tile the emitter never goes idle
  a_tile_cont: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && !last) |=> ev_q)
    else $error("emitter dropped a tile early");

  // a new tile starts at its first element
  a_tile_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (kcol_q == 2'd0 && krow_q == 2'd0))
    else $error("tile loaded mid-sequence");

endmodule

/* sim/msq_tile_checker.sv */
// checker for the marching squares tile renderer: follows apb writes and both item channels,
// predicts every rendered tile pixel and compares it with what the block hands out
// depends on msq_pkg for widths and register indexes
module msq_tile_checker
  import msq_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                apb_sel_i,
  input  logic                apb_enable_i,
  input  logic                apb_write_i,
  input  logic [APB_AW-1:0]   apb_addr_i,
  input  logic [APB_DW-1:0]   apb_wdata_i,
  input  logic                apb_ready_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic [PIX_W-1:0]    pixel_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [COORD_W-1:0]  x_i,
  input  logic [COORD_W-1:0]  y_i,
  input  logic [PIX_W-1:0]    colour_i,
  input  logic                last_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  localparam int unsigned TILE_COLS   = MAX_WIDTH / 3 + 1;
  localparam int unsigned MAX_REPORTS = 30;

  // element k of a tile in raster order is bit (8 - k)
  localparam logic [PAT_W-1:0] CASE_PATTERN [16] = '{
    9'h1FF, 9'h1D9, 9'h1F4, 9'h1C0, 9'h137, 9'h1AB, 9'h124, 9'h1A0,
    9'h05F, 9'h049, 9'h0EE, 9'h0C8, 9'h007, 9'h00B, 9'h026, 9'h000
  };

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [PIX_W-1:0]   colour;
    logic               last;
  } tile_pixel_t;

  logic [PIX_W-1:0]  thr_q;
  logic [PIX_W-1:0]  pos_q;
  logic [PIX_W-1:0]  neg_q;
  logic [SIZE_W-1:0] width_q;
  logic [SIZE_W-1:0] height_q;
  logic [1:0]        corner_bits_q [TILE_COLS];
  logic              left_bit_q;
  int unsigned       col_q;
  int unsigned       row_q;
  tile_pixel_t       tile_pixels_q [$];

  function automatic int unsigned size_in_use(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  task automatic predict_pixel(input logic [PIX_W-1:0] pix);
    int unsigned w, h, tcol, cpos, rpos, k;
    logic dark;
    logic [CODE_W-1:0] code;
    logic [PAT_W-1:0] pat;
    tile_pixel_t item;
    w = size_in_use(width_q, MAX_WIDTH);
    h = size_in_use(height_q, MAX_HEIGHT);
    dark = (pix <= thr_q);
    tcol = col_q / 3;
    cpos = col_q % 3;
    rpos = row_q % 3;
    // only pixels inside whole tiles touch the corner state
    if (col_q < (w / 3) * 3 && row_q < (h / 3) * 3) begin
      if (rpos == 0 && cpos == 0) begin
        corner_bits_q[tcol][1] = dark;
      end else if (rpos == 0 && cpos == 2) begin
        corner_bits_q[tcol][0] = dark;
      end else if (rpos == 2 && cpos == 0) begin
        left_bit_q = dark;
      end else if (rpos == 2 && cpos == 2) begin
        code = {corner_bits_q[tcol], dark, left_bit_q};
        pat = CASE_PATTERN[code];
        for (k = 0; k < 9; k++) begin
          item.x      = COORD_W'(tcol * 3 + k % 3);
          item.y      = COORD_W'(row_q - 2 + k / 3);
          item.colour = pat[PAT_W-1-k] ? pos_q : neg_q;
          item.last   = (k == 8);
          tile_pixels_q.push_back(item);
        end
      end
    end
    if (col_q + 1 >= w) begin
      col_q = 0;
      row_q = (row_q + 1 >= h) ? 0 : row_q + 1;
    end else begin
      col_q = col_q + 1;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    tile_pixel_t got, want;
    if (!rst_ni) begin
      thr_q        = RST_THRESHOLD;
      pos_q        = RST_FG_COLOUR;
      neg_q        = RST_BG_COLOUR;
      width_q      = RST_IMAGE_WIDTH;
      height_q     = RST_IMAGE_HEIGHT;
      left_bit_q   = 1'b0;
      col_q        = 0;
      row_q        = 0;
      fail_count_o = 0;
      tile_pixels_q.delete();
    end else begin
      if (apb_sel_i && apb_enable_i && apb_write_i && apb_ready_i) begin
        case (reg_idx_e'(apb_addr_i[4:2]))
          REG_THRESHOLD:    thr_q    = apb_wdata_i[PIX_W-1:0];
          REG_FG_COLOUR:    pos_q    = apb_wdata_i[PIX_W-1:0];
          REG_BG_COLOUR:    neg_q    = apb_wdata_i[PIX_W-1:0];
          REG_IMAGE_WIDTH:  width_q  = apb_wdata_i[SIZE_W-1:0];
          REG_IMAGE_HEIGHT: height_q = apb_wdata_i[SIZE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        got = '{x: x_i, y: y_i, colour: colour_i, last: last_i};
        if (tile_pixels_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= MAX_REPORTS)
            $display("%0t: unexpected item x=%0d y=%0d colour=%0d last=%0d", $time,
                     got.x, got.y, got.colour, got.last);
        end else begin
          want = tile_pixels_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.colour !== want.colour ||
              got.last !== want.last) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= MAX_REPORTS)
              $display("%0t: expected x=%0d y=%0d colour=%0d last=%0d, got x=%0d y=%0d %s",
                       $time, want.x, want.y, want.colour, want.last, got.x, got.y,
                       $sformatf("colour=%0d last=%0d", got.colour, got.last));
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_pixel(pixel_i);
    end
    pending_o = tile_pixels_q.size();
  end

endmodule

/* sim/tb_top.sv */
// top of the tile renderer testbench: clock, reset, apb writes, pixel stimulus and
// output back-pressure; checking is done by msq_tile_checker, the verdict is given here
// depends on msq_pkg, marching_squares_tile_renderer_core and msq_tile_checker
module tb_top;
  import msq_pkg::*;

  localparam int unsigned MAX_WIDTH      = 1024;
  localparam int unsigned MAX_HEIGHT     = 1024;
  localparam int unsigned RANDOM_ITEMS   = 100;
  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned CYCLE_LIMIT    = 400000;
  localparam int unsigned ADDR_SLOTS     = 2 ** $bits(reg_idx_e);

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [PIX_W-1:0]    pixel_i;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [COORD_W-1:0]  x_o;
  logic [COORD_W-1:0]  y_o;
  logic [PIX_W-1:0]    colour_o;
  logic                last_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;

  // what the stimulus side last wrote, so frames can be sized and pixels aimed near threshold
  logic [PIX_W-1:0]  thr_shadow;
  logic [SIZE_W-1:0] width_shadow;
  logic [SIZE_W-1:0] height_shadow;

  bit tail_quiet;
  bit rx_hold_req;
  bit rx_hold_done;

  marching_squares_tile_renderer_core #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .pixel_i    (pixel_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .x_o        (x_o),
    .y_o        (y_o),
    .colour_o   (colour_o),
    .last_o     (last_o)
  );

  msq_tile_checker #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .apb_sel_i   (psel),
    .apb_enable_i(penable),
    .apb_write_i (pwrite),
    .apb_addr_i  (paddr),
    .apb_wdata_i (pwdata),
    .apb_ready_i (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .pixel_i     (pixel_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .x_i         (x_o),
    .y_i         (y_o),
    .colour_i    (colour_o),
    .last_i      (last_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // run limit, far above the slowest correct run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output side: random short stalls, one long hold-off on request, none in the tail
  always begin
    @(negedge clk_i);
    if (rx_hold_req && !rx_hold_done) begin
      out_ready_i <= 1'b0;
      repeat (RX_HOLD_CYCLES) @(negedge clk_i);
      rx_hold_done = 1'b1;
    end else if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned frame_pixels();
    return eff_size(width_shadow, MAX_WIDTH) * eff_size(height_shadow, MAX_HEIGHT);
  endfunction

  // half of the pixels sit right at the dark/bright boundary
  function automatic logic [PIX_W-1:0] pick_pixel();
    int v;
    logic [PIX_W-1:0] p;
    if ($urandom_range(0, 1) == 0) begin
      p = PIX_W'($urandom_range(0, 255));
    end else begin
      v = int'(thr_shadow) + int'($urandom_range(0, 2)) - 1;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      p = PIX_W'(v);
    end
    return p;
  endfunction

  // setup and access phase; the block takes the write at the access edge (pready is high)
  task automatic write_reg(input logic [2:0] idx, input logic [APB_DW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_THRESHOLD:    thr_shadow    = value[PIX_W-1:0];
      REG_IMAGE_WIDTH:  width_shadow  = value[SIZE_W-1:0];
      REG_IMAGE_HEIGHT: height_shadow = value[SIZE_W-1:0];
      default: ;
    endcase
  endtask

  // offers one item and returns at the falling edge after it was taken, valid still high
  task automatic send_pixel(input logic [PIX_W-1:0] v);
    if (!tail_quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pixel_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // drop valid, wait for every expected item, then give in-flight work time to finish
  task automatic settle();
    in_valid_i <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // sender pauses once at item pause_at until everything expected has come out
  task automatic send_pixels(input int unsigned n, input int unsigned pause_at);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i == pause_at) settle();
      send_pixel(pick_pixel());
    end
  endtask

  initial begin
    int unsigned r, c, t, code_bit, rand_items, phase, npix, i;
    logic corner, dark;
    logic [PIX_W-1:0] v;

    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_valid_i    = 1'b0;
    pixel_i       = '0;
    tail_quiet    = 1'b0;
    rx_hold_req   = 1'b0;
    rx_hold_done  = 1'b0;
    thr_shadow    = RST_THRESHOLD;
    width_shadow  = RST_IMAGE_WIDTH;
    height_shadow = RST_IMAGE_HEIGHT;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // sweep of all sixteen case codes: one 48x3 frame, tile t carries code t,
    // corners sit exactly at the threshold or one above it, or at the range ends
    write_reg(REG_THRESHOLD, 32'd100);
    write_reg(REG_FG_COLOUR, 32'hA5);
    write_reg(REG_BG_COLOUR, 32'h5A);
    write_reg(REG_IMAGE_WIDTH, 32'd48);
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 48; c++) begin
        t = c / 3;
        corner = 1'b1;
        if (r == 0 && c % 3 == 0) code_bit = 3;
        else if (r == 0 && c % 3 == 2) code_bit = 2;
        else if (r == 2 && c % 3 == 2) code_bit = 1;
        else if (r == 2 && c % 3 == 0) code_bit = 0;
        else corner = 1'b0;
        if (corner) begin
          dark = t[code_bit];
          if (t % 2 == 0) v = dark ? thr_shadow : thr_shadow + 8'd1;
          else v = dark ? 8'd0 : 8'd255;
        end else begin
          v = PIX_W'($urandom_range(0, 255));
        end
        send_pixel(v);
      end
    end
    settle();

    // sizes below the minimum clamp to a single 3x3 tile; threshold at zero
    write_reg(REG_IMAGE_WIDTH, 32'd2);
    write_reg(REG_IMAGE_HEIGHT, 32'd1);
    write_reg(REG_THRESHOLD, 32'd0);
    send_pixels(frame_pixels(), '1);
    settle();

    // everything dark, colours swapped to the other extremes
    write_reg(REG_THRESHOLD, 32'd255);
    write_reg(REG_FG_COLOUR, 32'd0);
    write_reg(REG_BG_COLOUR, 32'd255);
    send_pixels(frame_pixels(), '1);
    settle();

    // addresses past the register list must change nothing
    for (i = int'(REG_IMAGE_HEIGHT) + 1; i < ADDR_SLOTS; i++) write_reg(i[2:0], $urandom);
    send_pixels(frame_pixels(), '1);
    settle();

    // partial tiles on the right edge and at the bottom
    write_reg(REG_THRESHOLD, 32'd128);
    write_reg(REG_IMAGE_WIDTH, 32'd7);
    write_reg(REG_IMAGE_HEIGHT, 32'd5);
    send_pixels(frame_pixels(), '1);
    settle();

    // width shrinks mid-frame: stopped at row 2 column 10 of a 12x9 frame, the next
    // pixel wraps to row 3, and 36 more close the 6x9 frame
    write_reg(REG_IMAGE_WIDTH, 32'd12);
    write_reg(REG_IMAGE_HEIGHT, 32'd9);
    send_pixels(34, '1);
    settle();
    write_reg(REG_IMAGE_WIDTH, 32'd6);
    send_pixels(37, '1);
    settle();
    // height shrinks mid-frame: stopped at row 7 column 2, the rest of row 7 wraps to row 0
    send_pixels(44, '1);
    settle();
    write_reg(REG_IMAGE_HEIGHT, 32'd6);
    send_pixels(4, '1);
    settle();

    // random frames, later ones with random settings; the first, 9x6, is held up at the output
    // for a long stretch, in the second the sender waits halfway for the block to drain
    rand_items = 0;
    phase = 0;
    while (rand_items < RANDOM_ITEMS) begin
      settle();
      if (phase == 0) begin
        write_reg(REG_IMAGE_WIDTH, 32'd9);
        write_reg(REG_IMAGE_HEIGHT, 32'd6);
        rx_hold_req = 1'b1;
      end else begin
        if ($urandom_range(0, 1) == 0) begin
          case ($urandom_range(0, 3))
            0: write_reg(REG_THRESHOLD, 32'd0);
            1: write_reg(REG_THRESHOLD, 32'd255);
            default: write_reg(REG_THRESHOLD, $urandom_range(0, 255));
          endcase
        end
        if ($urandom_range(0, 1) == 0) write_reg(REG_FG_COLOUR, $urandom_range(0, 255));
        if ($urandom_range(0, 1) == 0) write_reg(REG_BG_COLOUR, $urandom_range(0, 255));
        if ($urandom_range(0, 9) == 0) write_reg(REG_IMAGE_WIDTH, $urandom_range(0, 2));
        else write_reg(REG_IMAGE_WIDTH, $urandom_range(3, 9));
        if ($urandom_range(0, 9) == 0) write_reg(REG_IMAGE_HEIGHT, $urandom_range(0, 2));
        else write_reg(REG_IMAGE_HEIGHT, $urandom_range(3, 6));
        if ($urandom_range(0, 7) == 0)
          write_reg(3'($urandom_range(int'(REG_IMAGE_HEIGHT) + 1, ADDR_SLOTS - 1)), $urandom);
      end
      npix = frame_pixels();
      send_pixels(npix, (phase == 1) ? npix / 2 : '1);
      rand_items += npix;
      phase++;
    end

    // closing frame with no idling on either side
    settle();
    tail_quiet = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 32'd6);
    write_reg(REG_IMAGE_HEIGHT, 32'd6);
    send_pixels(frame_pixels(), '1);

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
